>>> rtl/apnm_pkg.sv
// shared types and constants of the ascii pnm raster formatter
`timescale 1ns / 1ps

package apnm_pkg;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  // pixel depth codes (the fourth code behaves as rgb)
  localparam logic [1:0] DEPTH_BITS = 2'd0;
  localparam logic [1:0] DEPTH_GREY = 2'd1;

  // text line limits
  localparam logic [4:0] LINE_VALUES = 5'd17;
  localparam logic [4:0] LINE_BYTES  = 5'd4;

  // reciprocal of ten for values below one hundred: x * 205 >> 11
  localparam logic [7:0] RECIP_TEN = 8'd205;
  localparam int         RECIP_SHIFT = 11;

  // default depth of the command queue
  localparam int CMD_DEPTH_DEF = 2;

  // one classified byte, ready for expansion into characters
  typedef struct packed {
    logic       is_bits;    // packed 1-bit mode
    logic [7:0] byte_val;   // raw byte for bit mode
    logic [4:0] nchar;      // body characters before the line break
    logic [7:0] ch_hund;
    logic [7:0] ch_tens;
    logic [7:0] ch_units;
    logic       line_end;   // append cr lf
    logic       image_end;  // flag the final lf
  } cmd_t;

endpackage

>>> rtl/apnm_front.sv
// front part: configuration registers, row and line bookkeeping, byte classification
`timescale 1ns / 1ps

module apnm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                accept,
  input  logic [7:0]          pixel_byte,
  output apnm_pkg::cmd_t      cmd
);

  logic [15:0] image_width_r;
  logic [15:0] image_height_r;
  logic [1:0]  pixel_depth_r;
  logic [17:0] column_count_r, column_count_nxt;
  logic [4:0]  line_fill_r, line_fill_nxt;
  logic [15:0] row_count_r, row_count_nxt;

  logic        is_bits;
  logic        col_past;
  logic [18:0] width_gap;
  logic [3:0]  bit_cnt;
  logic [17:0] col_inc;
  logic [17:0] row_len;
  logic        row_end;
  logic [4:0]  lf_inc;
  logic        line_end;
  logic [16:0] row_sum;
  logic        image_end;
  logic [1:0]  hund;
  logic [7:0]  hund_sub;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  units;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 16'd1;
      image_height_r <= 16'd1;
      pixel_depth_r  <= apnm_pkg::DEPTH_GREY;
    end else if (cfg_valid) begin
      case (cfg_index)
        apnm_pkg::REG_WIDTH:  image_width_r  <= cfg_data;
        apnm_pkg::REG_HEIGHT: image_height_r <= cfg_data;
        apnm_pkg::REG_DEPTH:  pixel_depth_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // bit mode: pixels left in the row, at least one, at most eight
  always_comb begin
    is_bits   = (pixel_depth_r == apnm_pkg::DEPTH_BITS);
    col_past  = (column_count_r >= {2'b00, image_width_r});
    width_gap = {3'b000, image_width_r} - {1'b0, column_count_r};
    if (col_past) begin
      bit_cnt = 4'd1;
    end else if (width_gap >= 19'd8) begin
      bit_cnt = 4'd8;
    end else begin
      bit_cnt = width_gap[3:0];
    end

    row_len = (pixel_depth_r == apnm_pkg::DEPTH_GREY) ? {2'b00, image_width_r}
            : ({2'b00, image_width_r} + {1'b0, image_width_r, 1'b0});

    if (is_bits) begin
      col_inc = column_count_r + {14'd0, bit_cnt};
      row_end = (col_inc >= {2'b00, image_width_r});
    end else begin
      col_inc = column_count_r + 18'd1;
      row_end = (col_inc >= row_len);
    end

    lf_inc    = line_fill_r + 5'd1;
    line_end  = row_end || (is_bits ? (lf_inc >= apnm_pkg::LINE_BYTES)
                                    : (lf_inc >= apnm_pkg::LINE_VALUES));
    row_sum   = {1'b0, row_count_r} + 17'd1;
    image_end = row_end && (row_sum >= {1'b0, image_height_r});

    column_count_nxt = row_end ? 18'd0 : col_inc;
    line_fill_nxt    = line_end ? 5'd0 : lf_inc;
    row_count_nxt    = row_end ? (image_end ? 16'd0 : row_sum[15:0]) : row_count_r;
  end

  // decimal digits of the byte
  always_comb begin
    if (pixel_byte >= 8'd200) begin
      hund     = 2'd2;
      hund_sub = 8'd200;
    end else if (pixel_byte >= 8'd100) begin
      hund     = 2'd1;
      hund_sub = 8'd100;
    end else begin
      hund     = 2'd0;
      hund_sub = 8'd0;
    end
    rem       = 7'(pixel_byte - hund_sub);
    tens_prod = {8'd0, rem} * {7'd0, apnm_pkg::RECIP_TEN};
    tens      = tens_prod[apnm_pkg::RECIP_SHIFT +: 4];
    tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
    units     = 4'(rem - tens_x10);
  end

  always_comb begin
    cmd.is_bits   = is_bits;
    cmd.byte_val  = pixel_byte;
    cmd.nchar     = is_bits ? {bit_cnt, 1'b0} : 5'd4;
    cmd.ch_hund   = (hund != 2'd0) ? (apnm_pkg::CH_ZERO + {6'd0, hund}) : apnm_pkg::CH_SPACE;
    cmd.ch_tens   = (hund != 2'd0 || tens != 4'd0) ? (apnm_pkg::CH_ZERO + {4'd0, tens})
                                                   : apnm_pkg::CH_SPACE;
    cmd.ch_units  = apnm_pkg::CH_ZERO + {4'd0, units};
    cmd.line_end  = line_end;
    cmd.image_end = image_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      line_fill_r    <= '0;
      row_count_r    <= '0;
    end else if (accept) begin
      column_count_r <= column_count_nxt;
      line_fill_r    <= line_fill_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  a_line_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (line_fill_r < apnm_pkg::LINE_VALUES))
    else $error("line fill left its range after a beat");

  a_image_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && image_end) |=> (column_count_r == 18'd0 && row_count_r == 16'd0))
    else $error("image end did not clear row and column");

endmodule

>>> rtl/apnm_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps

module apnm_cmd_fifo #(
  parameter int DEPTH = apnm_pkg::CMD_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  apnm_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output apnm_pkg::cmd_t rd_cmd,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  apnm_pkg::cmd_t    slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("command queue overfilled");

endmodule

>>> rtl/apnm_back.sv
// back part: expands a command into the output register, a char per cycle if not stalled
`timescale 1ns / 1ps

module apnm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  apnm_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_char,
  output logic           out_last_of_item,
  output logic           out_end_of_image
);

  logic [4:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       out_eoi_r;

  logic       slot_free;
  logic       advance;
  logic [4:0] total;
  logic       last;
  logic [7:0] ch;
  logic [2:0] bit_sel;

  assign slot_free = !out_valid_r || out_pop;
  assign advance   = !cmd_empty && slot_free;
  assign total     = cmd.nchar + (cmd.line_end ? 5'd2 : 5'd0);
  assign last      = (idx_r == total - 5'd1);
  assign cmd_pop   = advance && last;
  assign bit_sel   = ~idx_r[3:1];

  always_comb begin
    if (idx_r < cmd.nchar) begin
      if (cmd.is_bits) begin
        ch = idx_r[0] ? apnm_pkg::CH_SPACE
                      : (apnm_pkg::CH_ZERO + {7'd0, cmd.byte_val[bit_sel]});
      end else begin
        case (idx_r[1:0])
          2'd0:    ch = cmd.ch_hund;
          2'd1:    ch = cmd.ch_tens;
          2'd2:    ch = cmd.ch_units;
          default: ch = apnm_pkg::CH_SPACE;
        endcase
      end
    end else if (idx_r == cmd.nchar) begin
      ch = apnm_pkg::CH_CR;
    end else begin
      ch = apnm_pkg::CH_LF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r <= last ? 5'd0 : idx_r + 5'd1;
      end
      if (slot_free) begin
        out_valid_r <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r <= ch;
      out_last_r <= last;
      out_eoi_r  <= last && cmd.image_end;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_char         = out_char_r;
  assign out_last_of_item = out_last_r;
  assign out_end_of_image = out_eoi_r;

  a_eoi_on_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eoi_r) |-> (out_last_r && out_char_r == apnm_pkg::CH_LF))
    else $error("end of image not on the closing lf");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_empty |-> (idx_r < total))
    else $error("character index ran past the command");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (idx_r == 5'd0))
    else $error("index not rewound after a command");

endmodule

>>> rtl/ascii_pnm_raster_formatter_top.sv
// top level of the ascii pnm raster formatter
`timescale 1ns / 1ps

//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in_      | input     | in_push / in_full    | in_pixel_byte
//  out_     | output    | out_pop / out_empty  | out_char, out_last_of_item, out_end_of_image
//  cfg_     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  one character leaves per cycle while commands wait and out_pop is high; a byte yields
//  4 characters (grey or rgb) or 2 to 16 (packed bits), plus cr lf at a line or row end,
//  stepped through by the back part's character counter
//  the front takes a byte whenever the command queue has room
//  synchronous active-low reset clears counters, queue and output; registers return
//  to width 1, height 1, grey
//  a stalled out_pop freezes the output register, then the back, then fills the queue

module ascii_pnm_raster_formatter_top #(
  parameter int CMD_DEPTH = apnm_pkg::CMD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // raster bytes in
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_pixel_byte,
  // characters out
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_char,
  output logic        out_last_of_item,
  output logic        out_end_of_image
);

  apnm_pkg::cmd_t front_cmd;
  apnm_pkg::cmd_t head_cmd;
  logic           in_beat;
  logic           q_empty;
  logic           q_pop;

  // a beat is taken whenever the queue has room for its command
  assign in_beat = in_push && !in_full;

  apnm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (in_beat),
    .pixel_byte (in_pixel_byte),
    .cmd        (front_cmd)
  );

  // decouples classification from character expansion
  apnm_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .wr_cmd (front_cmd),
    .full   (in_full),
    .pop    (q_pop),
    .rd_cmd (head_cmd),
    .empty  (q_empty)
  );

  apnm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (head_cmd),
    .cmd_empty        (q_empty),
    .cmd_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_char         (out_char),
    .out_last_of_item (out_last_of_item),
    .out_end_of_image (out_end_of_image)
  );

  // the end-of-image character must also carry the item flag
  a_eoi_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_end_of_image) |-> out_last_of_item)
    else $error("end of image without end of item");

endmodule

>>> tb/ascii_pnm_raster_formatter_tb.sv
// self-checking testbench of the ascii pnm raster formatter
`timescale 1ns / 1ps

module testbench;

  // depth codes and a register index that the package leaves unnamed
  localparam logic [1:0] DEPTH_RGB     = 2'd2;
  localparam logic [1:0] DEPTH_RGB_ALT = 2'd3;
  localparam logic [1:0] REG_SPARE     = 2'd3;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX = 10;

  // one character beat as it should leave the block
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       eoi;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = apnm_pkg::REG_WIDTH;
  logic [15:0] cfg_data = 16'd0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_pixel_byte = 8'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_char;
  logic        out_last_of_item;
  logic        out_end_of_image;

  ascii_pnm_raster_formatter_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pixel_byte    (in_pixel_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_char         (out_char),
    .out_last_of_item (out_last_of_item),
    .out_end_of_image (out_end_of_image)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // formatter state mirrored by the predictor
  logic [15:0] fmt_width = 16'd1;
  logic [15:0] fmt_height = 16'd1;
  logic [1:0]  fmt_depth = apnm_pkg::DEPTH_GREY;
  logic [17:0] col_cnt = '0;
  logic [4:0]  line_fill = '0;
  logic [15:0] row_cnt = '0;

  logic [7:0]  pixel_q[$];      // bytes waiting for the driver
  char_beat_t  char_fifo[$];    // characters the block still owes us

  int bytes_queued = 0;
  int bytes_taken = 0;
  int chars_checked = 0;
  int formats = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic in_took = 1'b0;

  // predicts the characters for one raster byte and advances the row/line state
  function automatic void format_byte(input logic [7:0] b);
    logic [7:0]  chars[$];
    logic [7:0]  hund, tens, units;
    logic [17:0] row_len;
    logic        row_end, line_end, img_end;
    int          bitpos;
    img_end = 1'b0;
    if (fmt_depth == apnm_pkg::DEPTH_BITS) begin
      // msb first, at least one pixel even if the row is already full
      bitpos = 8;
      do begin
        bitpos--;
        chars.push_back(apnm_pkg::CH_ZERO + {7'd0, b[bitpos]});
        chars.push_back(apnm_pkg::CH_SPACE);
        col_cnt = col_cnt + 18'd1;
      end while (bitpos != 0 && col_cnt < {2'b00, fmt_width});
      line_fill = line_fill + 5'd1;
      row_end = col_cnt >= {2'b00, fmt_width};
      line_end = row_end || line_fill >= apnm_pkg::LINE_BYTES;
    end else begin
      // depth code three counts as rgb
      row_len = (fmt_depth == apnm_pkg::DEPTH_GREY) ? {2'b00, fmt_width}
                                                    : 18'(fmt_width) * 18'd3;
      hund = b / 8'd100;
      tens = (b / 8'd10) % 8'd10;
      units = b % 8'd10;
      chars.push_back((hund != 0) ? apnm_pkg::CH_ZERO + hund : apnm_pkg::CH_SPACE);
      chars.push_back((tens != 0 || hund != 0) ? apnm_pkg::CH_ZERO + tens
                                               : apnm_pkg::CH_SPACE);
      chars.push_back(apnm_pkg::CH_ZERO + units);
      chars.push_back(apnm_pkg::CH_SPACE);
      col_cnt = col_cnt + 18'd1;
      line_fill = line_fill + 5'd1;
      row_end = col_cnt >= row_len;
      line_end = row_end || line_fill >= apnm_pkg::LINE_VALUES;
    end
    if (line_end) begin
      chars.push_back(apnm_pkg::CH_CR);
      chars.push_back(apnm_pkg::CH_LF);
      line_fill = '0;
    end
    if (row_end) begin
      col_cnt = '0;
      if ({1'b0, row_cnt} + 17'd1 >= {1'b0, fmt_height}) begin
        img_end = 1'b1;
        row_cnt = '0;
      end else begin
        row_cnt = row_cnt + 16'd1;
      end
    end
    foreach (chars[i])
      char_fifo.push_back('{chars[i], i == chars.size() - 1,
                            (i == chars.size() - 1) && img_end});
  endfunction

  // input driver: a byte offered stays on the port until the block takes it
  always @(negedge clk) begin : byte_driver
    logic go;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_took) begin
      go = pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (go) in_pixel_byte <= pixel_q.pop_front();
      in_push <= go;
    end
  end

  // output receiver: random pops, plus one long hold-off that backs the block up
  always @(negedge clk) begin : char_receiver
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= rst_n && $urandom_range(99) >= recv_idle_pct;
    end
  end

  // monitor: checks output beats first, then predicts from the input beat
  always @(posedge clk) begin : beat_monitor
    char_beat_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        chars_checked++;
        if (char_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] unexpected char %h last %b eoi %b", $time, out_char,
                     out_last_of_item, out_end_of_image);
        end else begin
          want = char_fifo.pop_front();
          if (out_char !== want.ch || out_last_of_item !== want.last ||
              out_end_of_image !== want.eoi) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("[%0t] char exp %h/%b/%b got %h/%b/%b", $time, want.ch, want.last,
                       want.eoi, out_char, out_last_of_item, out_end_of_image);
          end
        end
      end
      if (in_push && !in_full) begin
        format_byte(in_pixel_byte);
        bytes_taken++;
        in_took = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout: %0d of %0d bytes taken, %0d chars owed", bytes_taken, bytes_queued,
               char_fifo.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void queue_byte(input logic [7:0] b);
    pixel_q.push_back(b);
    bytes_queued++;
  endfunction

  // every byte taken and every character seen
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || char_fifo.size() != 0) @(negedge clk);
  endtask

  // one register write beat on the config channel, mirrored into the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      apnm_pkg::REG_WIDTH:  fmt_width = val;
      apnm_pkg::REG_HEIGHT: fmt_height = val;
      apnm_pkg::REG_DEPTH:  fmt_depth = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers only change once the block has gone quiet
  task automatic set_format(input logic [15:0] w, input logic [15:0] h, input logic [1:0] d);
    wait_drained();
    write_reg(apnm_pkg::REG_WIDTH, w);
    write_reg(apnm_pkg::REG_HEIGHT, h);
    write_reg(apnm_pkg::REG_DEPTH, d);
    formats++;
  endtask

  // random formats, mostly small so rows and images close often
  task automatic random_run(input int n_bytes);
    int left, n, pick;
    logic [15:0] w, h;
    left = n_bytes;
    while (left > 0) begin
      n = $urandom_range(15, 45);
      if (n > left) n = left;
      pick = $urandom_range(19);
      w = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0 :
          (pick == 2) ? 16'($urandom) : 16'($urandom_range(1, 40));
      pick = $urandom_range(19);
      h = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0 :
          (pick == 2) ? 16'($urandom) : 16'($urandom_range(1, 4));
      set_format(w, h, 2'($urandom_range(3)));
      repeat (n) begin
        pick = $urandom_range(7);
        queue_byte((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom));
      end
      left -= n;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles often, receiver mostly stalls
    send_idle_pct = 37;
    recv_idle_pct = 79;

    // reset format: grey, one pixel per row, one row per image
    queue_byte(8'd0);
    queue_byte(8'd255);

    // grey digit boundaries; a write to the spare index must change nothing
    set_format(16'd20, 16'd3, apnm_pkg::DEPTH_GREY);
    write_reg(REG_SPARE, 16'hFFFF);
    queue_byte(8'd9);
    queue_byte(8'd10);
    queue_byte(8'd99);
    queue_byte(8'd100);
    queue_byte(8'd200);
    queue_byte(8'd7);

    // switch to bits with the text line already past four bytes: line break only
    set_format(16'd16, 16'd1, apnm_pkg::DEPTH_BITS);
    queue_byte(8'h80);

    // zero width and zero height: top bit only, row and image end at once
    set_format(16'd0, 16'd0, apnm_pkg::DEPTH_BITS);
    queue_byte(8'h7F);

    // padding bits past the row end are dropped
    set_format(16'd11, 16'd2, apnm_pkg::DEPTH_BITS);
    queue_byte(8'hA5);
    queue_byte(8'h5A);
    queue_byte(8'hFF);

    // fourth depth code behaves as rgb, row shrunk below the column count
    set_format(16'd1, 16'd1, DEPTH_RGB_ALT);
    queue_byte(8'd1);
    queue_byte(8'd2);
    queue_byte(8'd3);

    // largest sizes
    set_format(16'hFFFF, 16'hFFFF, DEPTH_RGB);
    queue_byte(8'd255);
    queue_byte(8'd0);
    set_format(16'hFFFF, 16'hFFFF, apnm_pkg::DEPTH_BITS);
    queue_byte(8'hC3);

    random_run(160);

    // roles swapped
    wait_drained();
    send_idle_pct = 79;
    recv_idle_pct = 37;
    random_run(160);

    // full rate, opening with a long receiver hold-off so the input backs up
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_run(160);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d raster bytes over %0d formats, %0d characters checked", bytes_taken,
             formats, chars_checked);
    $display("%0d mismatches, %0d characters never arrived", mismatches, char_fifo.size());
    if (mismatches == 0 && char_fifo.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/apnm_pkg.sv
rtl/apnm_front.sv
rtl/apnm_cmd_fifo.sv
rtl/apnm_back.sv
rtl/ascii_pnm_raster_formatter_top.sv
tb/ascii_pnm_raster_formatter_tb.sv
